### src/y2b_pkg.sv
// Shared types, constants and arithmetic helpers for the YUY2 to BGR24 converter.
// No dependencies; imported by y2b_color and yuy2_to_bgr24_converter.
package y2b_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned ProdWidth = 18;   // widest constant product, signed
   localparam int unsigned TermWidth = 10;   // product / 256, signed
   localparam int unsigned SumWidth  = 11;   // luma term + chroma term, signed

   localparam logic [ByteWidth-1:0] LumaBlack  = 8'd16;
   localparam logic [ByteWidth-1:0] ChromaZero = 8'd128;
   localparam logic signed [ProdWidth-1:0] LumaGain   = 18'sd298;
   localparam logic signed [ProdWidth-1:0] RedVGain   = 18'sd459;
   localparam logic signed [ProdWidth-1:0] GreenUGain = -18'sd137;
   localparam logic signed [ProdWidth-1:0] GreenVGain = 18'sd55;
   localparam logic signed [ProdWidth-1:0] BlueUGain  = 18'sd541;
   localparam logic signed [ProdWidth-1:0] RoundUp    = 18'sd255;  // 256 - 1
   localparam logic signed [SumWidth-1:0]  ChannelMax = 11'sd255;

   typedef struct packed {
      logic [ByteWidth-1:0] luma_first;
      logic [ByteWidth-1:0] chroma_blue;
      logic [ByteWidth-1:0] luma_second;
      logic [ByteWidth-1:0] chroma_red;
   } yuy2_group_type;

   typedef struct packed {
      logic [ByteWidth-1:0] blue_first;
      logic [ByteWidth-1:0] green_first;
      logic [ByteWidth-1:0] red_first;
      logic [ByteWidth-1:0] blue_second;
      logic [ByteWidth-1:0] green_second;
      logic [ByteWidth-1:0] red_second;
   } bgr_pair_type;

   // Divide by 256, truncating toward zero: bias negative values before the shift.
   function automatic logic signed [TermWidth-1:0] div256(
      input logic signed [ProdWidth-1:0] prod);
      logic signed [ProdWidth-1:0] biased;
      biased = prod + (prod[ProdWidth-1] ? RoundUp : '0);
      return signed'(biased[ProdWidth-1:ProdWidth-TermWidth]);
   endfunction

   // Saturate a signed channel sum to 0..255.
   function automatic logic [ByteWidth-1:0] clamp_channel(
      input logic signed [SumWidth-1:0] sum);
      logic [ByteWidth-1:0] result;
      if (sum[SumWidth-1]) begin
         result = '0;
      end else if (sum > ChannelMax) begin
         result = '1;
      end else begin
         result = sum[ByteWidth-1:0];
      end
      return result;
   endfunction

endpackage

### src/y2b_color.sv
// Color-space arithmetic for one YUY2 group: luma and chroma terms, sums, clamps.
// Depends on y2b_pkg; purely combinational, placed between the converter's registers.
module y2b_color (
   input  y2b_pkg::yuy2_group_type group_in,
   output y2b_pkg::bgr_pair_type   pixels_out
);
   import y2b_pkg::*;

   logic signed [ProdWidth-1:0] y0_off, y1_off, u_off, v_off;
   logic signed [TermWidth-1:0] luma0, luma1, chroma_r, chroma_g, chroma_b;

   // Offset removal; products stay within 18 signed bits.
   assign y0_off = signed'({{(ProdWidth-ByteWidth){1'b0}}, group_in.luma_first})
                 - signed'({{(ProdWidth-ByteWidth){1'b0}}, LumaBlack});
   assign y1_off = signed'({{(ProdWidth-ByteWidth){1'b0}}, group_in.luma_second})
                 - signed'({{(ProdWidth-ByteWidth){1'b0}}, LumaBlack});
   assign u_off  = signed'({{(ProdWidth-ByteWidth){1'b0}}, group_in.chroma_blue})
                 - signed'({{(ProdWidth-ByteWidth){1'b0}}, ChromaZero});
   assign v_off  = signed'({{(ProdWidth-ByteWidth){1'b0}}, group_in.chroma_red})
                 - signed'({{(ProdWidth-ByteWidth){1'b0}}, ChromaZero});

   assign luma0    = div256(y0_off * LumaGain);
   assign luma1    = div256(y1_off * LumaGain);
   assign chroma_r = div256(v_off * RedVGain);
   assign chroma_g = div256(u_off * GreenUGain - v_off * GreenVGain);
   assign chroma_b = div256(u_off * BlueUGain);

   assign pixels_out.blue_first   = clamp_channel(SumWidth'(luma0) + SumWidth'(chroma_b));
   assign pixels_out.green_first  = clamp_channel(SumWidth'(luma0) + SumWidth'(chroma_g));
   assign pixels_out.red_first    = clamp_channel(SumWidth'(luma0) + SumWidth'(chroma_r));
   assign pixels_out.blue_second  = clamp_channel(SumWidth'(luma1) + SumWidth'(chroma_b));
   assign pixels_out.green_second = clamp_channel(SumWidth'(luma1) + SumWidth'(chroma_g));
   assign pixels_out.red_second   = clamp_channel(SumWidth'(luma1) + SumWidth'(chroma_r));

endmodule

### src/yuy2_to_bgr24_converter.sv
// YUY2 to BGR24 converter top level: one group of Y0 U Y1 V in, two BGR pixels out.
// Depends on y2b_pkg and y2b_color.
// Path: input register, y2b_color, then the result register that drives rsp_valid and rsp_data.
// Throughput: one group per clock; busy stays low since results are never held off.
// Reset (synchronous, active high) clears the two valid flags only; data registers hold.
module yuy2_to_bgr24_converter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  y2b_pkg::yuy2_group_type req_data,
   output logic                    rsp_valid,
   output y2b_pkg::bgr_pair_type   rsp_data
);
   import y2b_pkg::*;

   logic           in_valid_ff, in_valid_in;
   yuy2_group_type in_data_ff;
   logic           out_valid_ff, out_valid_in;
   bgr_pair_type   out_data_ff, out_data_in;

   // Every stage advances each cycle and the receiver always takes the result,
   // so there is nothing to stall on.
   assign busy = 1'b0;

   // Capture the group on a transfer.
   assign in_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_data_ff <= req_data;
      end
   end

   // Single pass of color arithmetic between the two registers.
   y2b_color u_color (
      .group_in   (in_data_ff),
      .pixels_out (out_data_in)
   );

   // Result register: each result is shown for exactly one cycle.
   assign out_valid_in = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_in) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Every transfer yields a result after passing the input and result registers.
   a_transfer_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("transfer produced no result");

   // No result without a matching transfer passed through the input and result registers.
   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without transfer");

   // Equal luma bytes share chroma, so both pixels must match.
   a_equal_luma_equal_pixels: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_data.luma_first, 2) == $past(req_data.luma_second, 2)))
      |-> (rsp_data.blue_first == rsp_data.blue_second
           && rsp_data.green_first == rsp_data.green_second
           && rsp_data.red_first == rsp_data.red_second))
      else $error("pixels differ for equal luma");

endmodule
